[hw/rtl/bpsn_pkg.sv]
// Shared constants and types for the Bezier point set normalizer.
package bpsn_pkg;

  localparam int unsigned MaxPointsDefault = 16;
  localparam int unsigned CoordBitsDefault = 24;
  localparam int unsigned FracBits         = 16;
  localparam int unsigned NumLanes         = 6;
  localparam int unsigned IndexBits        = 4;
  localparam int unsigned ScaleBits        = 32;
  localparam logic [16:0] K1p9             = 17'd124518;
  localparam logic [15:0] K0p95            = 16'd62259;
  // Dividend width: K1p9 << 32.
  localparam int unsigned DivBits          = 49;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_DIV,
    ST_EMIT
  } state_e;

  // Control from the sequencer to the lanes.
  typedef struct packed {
    logic load;   // store the input word
    logic first;  // first point of a set: restart the box
  } lane_ctrl_t;

endpackage

[hw/rtl/bezier_point_set_normalizer_core.sv]
// Bezier point set normalizer top level: sequencer, six coordinate lanes,
// box merge and scale divider.
//
// Points are loaded one per cycle into six lanes (one per coordinate), each
// with its own RAM and min/max tracker. A point marked last is stored in the
// same cycle; the lanes' boxes are then merged into one x and one y box, and
// a bit-serial divider forms the scale after the merge state, ST_DIV
// (skipped when a span is zero). The stored points then stream out through a
// three-stage read, subtract and multiply path into the output register; a
// new point is issued only once the previous word is taken. Input is held
// off while a set is being normalized and emitted.
module bezier_point_set_normalizer_core import bpsn_pkg::*; #(
  parameter int unsigned MaxPoints = MaxPointsDefault,
  parameter int unsigned CoordBits = CoordBitsDefault
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic signed [CoordBits-1:0] in_x_i,
  input  logic signed [CoordBits-1:0] in_y_i,
  input  logic signed [CoordBits-1:0] pos_x_i,
  input  logic signed [CoordBits-1:0] pos_y_i,
  input  logic signed [CoordBits-1:0] out_x_i,
  input  logic signed [CoordBits-1:0] out_y_i,
  input  logic                        last_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic signed [CoordBits-1:0] res_in_x_o,
  output logic signed [CoordBits-1:0] res_in_y_o,
  output logic signed [CoordBits-1:0] res_pos_x_o,
  output logic signed [CoordBits-1:0] res_pos_y_o,
  output logic signed [CoordBits-1:0] res_out_x_o,
  output logic signed [CoordBits-1:0] res_out_y_o,
  output logic [IndexBits-1:0]        point_index_o,
  output logic                        last_out_o,
  output logic                        overflowed_o
);

  localparam int unsigned AddrBits = (MaxPoints > 1) ? $clog2(MaxPoints) : 1;
  localparam int unsigned CntBits  = $clog2(MaxPoints + 1);
  localparam int unsigned PipeLen  = 3;

  state_e state_q, state_d;
  logic [CntBits-1:0]  count_q, count_d;
  logic                drop_q, drop_d;
  logic [CntBits-1:0]  rd_q, rd_d;      // next point to issue
  logic [CntBits-1:0]  inflight_q;      // issued, not yet taken
  logic [PipeLen-1:0]  pipe_v_q;
  logic [CntBits-1:0]  pidx_q [PipeLen];
  logic [DivBits-1:0]  scale_q;
  logic                raw_q;
  logic signed [CoordBits-1:0] lox_q, loy_q;
  logic                div_start, div_done;
  logic [DivBits-1:0]  quot;

  logic accept, store, issue;
  lane_ctrl_t ctrl;
  logic signed [CoordBits-1:0] coord [NumLanes];
  logic signed [CoordBits-1:0] lmin [NumLanes], lmax [NumLanes], lres [NumLanes];
  logic signed [CoordBits-1:0] mnx, mxx, mny, mxy;
  logic [CoordBits:0] sx, sy, span;

  assign coord[0] = in_x_i;
  assign coord[1] = in_y_i;
  assign coord[2] = pos_x_i;
  assign coord[3] = pos_y_i;
  assign coord[4] = out_x_i;
  assign coord[5] = out_y_i;

  assign in_ready_o = (state_q == ST_LOAD);
  assign accept     = in_valid_i && in_ready_o;
  assign store      = accept && (count_q < CntBits'(MaxPoints));
  assign ctrl.load  = store;
  assign ctrl.first = (count_q == '0);

  // Lanes: x lanes read min_x, y lanes read min_y.
  for (genvar l = 0; l < NumLanes; l++) begin : g_lane
    bpsn_lane #(.CoordBits(CoordBits), .MaxPoints(MaxPoints)) u_lane (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl),
      .waddr_i (count_q[AddrBits-1:0]),
      .coord_i (coord[l]),
      .raddr_i (rd_q[AddrBits-1:0]),
      .lo_i    ((l % 2 == 0) ? lox_q : loy_q),
      .scale_i (scale_q),
      .raw_i   (raw_q),
      .min_o   (lmin[l]),
      .max_o   (lmax[l]),
      .res_o   (lres[l])
    );
  end

  // Merge: the box starts at the in handle lanes' box, then takes in the pos and out lanes.
  always_comb begin
    mnx = lmin[0]; mxx = lmax[0]; mny = lmin[1]; mxy = lmax[1];
    for (int l = 2; l < NumLanes; l += 2) begin
      if (lmin[l] < mnx) mnx = lmin[l];
      if (lmax[l] > mxx) mxx = lmax[l];
      if (lmin[l+1] < mny) mny = lmin[l+1];
      if (lmax[l+1] > mxy) mxy = lmax[l+1];
    end
    sx   = {mxx[CoordBits-1], mxx} - {mnx[CoordBits-1], mnx};
    sy   = {mxy[CoordBits-1], mxy} - {mny[CoordBits-1], mny};
    span = (sx > sy) ? sx : sy;
  end

  bpsn_divider #(.CoordBits(CoordBits)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .span_i  (span),
    .done_o  (div_done),
    .quot_o  (quot)
  );

  logic pipe_free;
  logic out_take;
  assign out_take  = out_valid_o && out_ready_i;
  // issue only with room to land in the output without loss
  assign pipe_free = (inflight_q - CntBits'(out_take)) < CntBits'(1);

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    drop_d    = drop_q;
    rd_d      = rd_q;
    div_start = 1'b0;
    issue     = 1'b0;
    unique case (state_q)
      ST_LOAD: begin
        if (accept) begin
          if (store) count_d = count_q + 1'b1;
          else       drop_d  = 1'b1;
          if (last_i) state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        // box is settled here; start divider unless a span is zero
        if (sx == '0 || sy == '0) begin
          state_d = ST_EMIT;
          rd_d    = '0;
        end else begin
          div_start = 1'b1;
          state_d   = ST_EMIT;
          rd_d      = count_q; // park until scale ready
        end
      end
      ST_EMIT: begin
        if (div_done) rd_d = '0;
        if (rd_q < count_q && pipe_free) begin
          issue = 1'b1;
          rd_d  = rd_q + 1'b1;
        end
        if (out_take && last_out_o) begin
          state_d = ST_LOAD;
          count_d = '0;
          drop_d  = 1'b0;
        end
      end
      default: state_d = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_LOAD;
      count_q    <= '0;
      drop_q     <= 1'b0;
      rd_q       <= '0;
      pipe_v_q   <= '0;
      inflight_q <= '0;
      raw_q      <= 1'b0;
    end else begin
      state_q    <= state_d;
      count_q    <= count_d;
      drop_q     <= drop_d;
      rd_q       <= rd_d;
      pipe_v_q   <= {pipe_v_q[PipeLen-2:0], issue};
      inflight_q <= inflight_q + CntBits'(issue) - CntBits'(out_take);
      if (state_q == ST_DIV) raw_q <= (sx == '0 || sy == '0);
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_DIV) begin
      lox_q <= mnx;
      loy_q <= mny;
    end
    if (div_done) scale_q <= quot;
    pidx_q[0] <= rd_q;
    for (int s = 1; s < PipeLen; s++) pidx_q[s] <= pidx_q[s-1];
  end

  // Output register: one word held until taken.
  logic                 ov_q;
  logic [CntBits-1:0]   oidx_q;
  logic signed [CoordBits-1:0] ores_q [NumLanes];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (pipe_v_q[PipeLen-1]) begin
      ov_q <= 1'b1;
    end else if (out_take) begin
      ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_v_q[PipeLen-1]) begin
      oidx_q <= pidx_q[PipeLen-1];
      for (int l = 0; l < NumLanes; l++) ores_q[l] <= lres[l];
    end
  end

  assign out_valid_o   = ov_q;
  assign res_in_x_o    = ores_q[0];
  assign res_in_y_o    = ores_q[1];
  assign res_pos_x_o   = ores_q[2];
  assign res_pos_y_o   = ores_q[3];
  assign res_out_x_o   = ores_q[4];
  assign res_out_y_o   = ores_q[5];
  assign point_index_o = IndexBits'(oidx_q);
  assign last_out_o    = (oidx_q + 1'b1 == count_q);
  assign overflowed_o  = drop_q;

endmodule

[hw/rtl/bpsn_ram.sv]
// Generic single-write, registered-read RAM.
module bpsn_ram #(
  parameter int unsigned Width = 48,
  parameter int unsigned Depth = 16
) (
  input  logic                                       clk_i,
  input  logic                                       we_i,
  input  logic [$clog2((Depth > 1) ? Depth : 2)-1:0] waddr_i,
  input  logic [Width-1:0]                           wdata_i,
  input  logic [$clog2((Depth > 1) ? Depth : 2)-1:0] raddr_i,
  output logic [Width-1:0]                           rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[hw/rtl/bpsn_divider.sv]
// Restoring divider: (1.9 in Q1.16 << 32) / span, one quotient bit per cycle.
module bpsn_divider import bpsn_pkg::*; #(
  parameter int unsigned CoordBits = CoordBitsDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [CoordBits:0]   span_i,
  output logic                 done_o,
  output logic [DivBits-1:0]   quot_o
);

  localparam int unsigned CntBits = $clog2(DivBits + 1);

  logic [CntBits-1:0]  cnt_q, cnt_d;
  logic                busy_q, busy_d;
  logic [DivBits-1:0]  num_q, num_d;
  logic [CoordBits+1:0] rem_q, rem_d;
  logic [CoordBits:0]  den_q, den_d;
  logic [CoordBits+1:0] trial;

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    num_d  = num_q;
    rem_d  = rem_q;
    den_d  = den_q;
    done_o = 1'b0;
    trial  = {rem_q[CoordBits:0], num_q[DivBits-1]};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CntBits'(DivBits);
      num_d  = {K1p9, {ScaleBits{1'b0}}};
      rem_d  = '0;
      den_d  = span_i;
    end else if (busy_q) begin
      // shift in one dividend bit, subtract when it fits
      if (trial >= {1'b0, den_q}) begin
        rem_d = trial - {1'b0, den_q};
        num_d = {num_q[DivBits-2:0], 1'b1};
      end else begin
        rem_d = trial;
        num_d = {num_q[DivBits-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntBits'(1)) begin
        busy_d = 1'b0;
        done_o = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  // Quotient: in num_q after the last step, in num_d (quot_o) with done_o.
  assign quot_o = num_d;

endmodule

[hw/rtl/bpsn_lane.sv]
// One coordinate lane: stores one coordinate per point, tracks its min/max,
// and maps stored values with the shared scale, or passes them raw.
module bpsn_lane import bpsn_pkg::*; #(
  parameter int unsigned CoordBits = CoordBitsDefault,
  parameter int unsigned MaxPoints = MaxPointsDefault
) (
  input  logic                                               clk_i,
  input  logic                                               rst_ni,
  input  lane_ctrl_t                                         ctrl_i,
  input  logic [$clog2((MaxPoints > 1) ? MaxPoints : 2)-1:0] waddr_i,
  input  logic signed [CoordBits-1:0]                        coord_i,
  input  logic [$clog2((MaxPoints > 1) ? MaxPoints : 2)-1:0] raddr_i,
  input  logic signed [CoordBits-1:0]                        lo_i,
  input  logic [DivBits-1:0]                                 scale_i,
  input  logic                                               raw_i,
  output logic signed [CoordBits-1:0]                        min_o,
  output logic signed [CoordBits-1:0]                        max_o,
  output logic signed [CoordBits-1:0]                        res_o
);

  localparam int unsigned AddrBits = $clog2((MaxPoints > 1) ? MaxPoints : 2);

  logic [CoordBits-1:0]        rdata;
  logic signed [CoordBits-1:0] min_q, max_q;
  logic [CoordBits:0]          diff_q;
  logic                        raw_q;
  logic [CoordBits-1:0]        rawv_q;
  logic [CoordBits+ScaleBits:0] prod_lo_q;
  logic [CoordBits+DivBits-ScaleBits:0] prod_hi_q;
  logic [CoordBits:0]          diff;

  bpsn_ram #(.Width(CoordBits), .Depth(MaxPoints)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ctrl_i.load),
    .waddr_i (waddr_i[AddrBits-1:0]),
    .wdata_i (coord_i),
    .raddr_i (raddr_i),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q <= '0;
      max_q <= '0;
    end else if (ctrl_i.load) begin
      if (ctrl_i.first) begin
        min_q <= coord_i;
        max_q <= coord_i;
      end else begin
        if (coord_i < min_q) min_q <= coord_i;
        if (coord_i > max_q) max_q <= coord_i;
      end
    end
  end

  assign diff = {rdata[CoordBits-1], rdata} - {lo_i[CoordBits-1], lo_i};

  // Two stages after the RAM read: subtract, then multiply.
  // Multiply by the scale's fraction and integer parts separately.
  always_ff @(posedge clk_i) begin
    diff_q    <= diff;
    raw_q     <= raw_i;
    rawv_q    <= rdata;
    prod_lo_q <= diff_q * scale_i[ScaleBits-1:0];
    prod_hi_q <= diff_q * scale_i[DivBits-1:ScaleBits];
  end

  logic [CoordBits-1:0] rawv2_q;
  logic                 raw2_q;
  always_ff @(posedge clk_i) begin
    rawv2_q <= rawv_q;
    raw2_q  <= raw_q;
  end

  logic [CoordBits:0] mapped;
  assign mapped = prod_hi_q[CoordBits:0]
                + prod_lo_q[CoordBits+ScaleBits:ScaleBits]
                - {{(CoordBits+1-16){1'b0}}, K0p95};
  assign res_o  = raw2_q ? rawv2_q : mapped[CoordBits-1:0];
  assign min_o  = min_q;
  assign max_o  = max_q;

endmodule
